@@ hdl/rgc_pkg.sv @@
// rgc_pkg: shared types, gradient tables and arithmetic helpers for the
// RGB565 gradient colorizer. No dependencies; all files but rgc_div_cell import it.
package rgc_pkg;

  // Default longest line; sets the width of the column and width ports.
  localparam int MaxLineDefault = 1024;

  // Fraction widths: t and u are Q1.16, the quotient part is 16 bits.
  localparam int FracW = 16;
  localparam int TW    = FracW + 1;

  localparam logic [TW-1:0] QOne = 17'd65536;
  localparam logic [TW-1:0] Q017 = 17'd11141;
  localparam logic [TW-1:0] Q033 = 17'd21627;
  localparam logic [TW-1:0] Q050 = 17'd32768;
  localparam logic [TW-1:0] Q067 = 17'd43909;
  localparam logic [TW-1:0] Q083 = 17'd54395;

  localparam logic [15:0] White = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_WHITE   = 3'd0,
    MODE_RAINBOW = 3'd1,
    MODE_FIRE    = 3'd2,
    MODE_OCEAN   = 3'd3,
    MODE_SUNSET  = 3'd4,
    MODE_MATRIX  = 3'd5
  } gradient_mode_e;

  // One gradient segment as seen by the second divider.
  typedef struct packed {
    logic          white;
    logic [TW-1:0] start;
    logic [TW-1:0] len;
    logic [15:0]   c1;
    logic [15:0]   c2;
  } seg_t;

  // Side data carried along the second divider to the blend stage.
  typedef struct packed {
    logic        full;
    logic        white;
    logic [15:0] c1;
    logic [15:0] c2;
  } blend_pay_t;

  function automatic seg_t mk_seg(logic [TW-1:0] s, logic [TW-1:0] e,
                                  logic [15:0] a, logic [15:0] b);
    seg_t r;
    r.white = 1'b0;
    r.start = s;
    r.len   = e - s;
    r.c1    = a;
    r.c2    = b;
    return r;
  endfunction

  // Pick the segment of the selected gradient that holds t.
  function automatic seg_t seg_lookup(logic [2:0] mode, logic [TW-1:0] t);
    seg_t r;
    r = mk_seg('0, QOne, White, White);
    r.white = 1'b1;
    unique case (mode)
      MODE_RAINBOW: begin
        priority if (t >= Q083) r = mk_seg(Q083, QOne, 16'h780F, 16'hF81F);
        else if (t >= Q067)     r = mk_seg(Q067, Q083, 16'h001F, 16'h780F);
        else if (t >= Q050)     r = mk_seg(Q050, Q067, 16'h07E0, 16'h001F);
        else if (t >= Q033)     r = mk_seg(Q033, Q050, 16'hFFE0, 16'h07E0);
        else if (t >= Q017)     r = mk_seg(Q017, Q033, 16'hFC00, 16'hFFE0);
        else                    r = mk_seg('0,   Q017, 16'hF800, 16'hFC00);
      end
      MODE_FIRE: begin
        if (t >= Q050) r = mk_seg(Q050, QOne, 16'hF800, 16'hFFE0);
        else           r = mk_seg('0,   Q050, 16'h7800, 16'hF800);
      end
      MODE_OCEAN: begin
        if (t >= Q050) r = mk_seg(Q050, QOne, 16'h07FF, 16'hAD55);
        else           r = mk_seg('0,   Q050, 16'h0010, 16'h07FF);
      end
      MODE_SUNSET: begin
        if (t >= Q050) r = mk_seg(Q050, QOne, 16'hF81F, 16'hFC00);
        else           r = mk_seg('0,   Q050, 16'h780F, 16'hF81F);
      end
      MODE_MATRIX: r = mk_seg('0, QOne, 16'h0200, 16'h07E0);
      default: ;
    endcase
    return r;
  endfunction

  // floor(a + (b - a) * u / 65536) for one channel, a and b up to 6 bits.
  // The true sum stays in [0, 2^22), so modular arithmetic is exact.
  function automatic logic [5:0] blend_ch(logic [5:0] a, logic [5:0] b,
                                          logic [TW-1:0] u);
    logic [6:0]  diff;
    logic [23:0] prod;
    logic [23:0] acc;
    diff = {1'b0, b} - {1'b0, a};
    prod = {{17{diff[6]}}, diff} * {7'd0, u};
    acc  = {2'b00, a, 16'h0000} + prod;
    return acc[21:16];
  endfunction

endpackage

@@ hdl/rgc_div_cell.sv @@
// rgc_div_cell: one restoring-division step with its own pipeline register.
// Generic in divisor, quotient and side-data widths; no package needed.
module rgc_div_cell #(
  parameter int DIV_W  = 11,
  parameter int QUOT_W = 16,
  parameter int PAY_W  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [DIV_W-1:0]  div_i,
  input  logic [QUOT_W-1:0] quot_i,
  input  logic [PAY_W-1:0]  pay_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DIV_W-1:0]  rem_o,
  output logic [DIV_W-1:0]  div_o,
  output logic [QUOT_W-1:0] quot_o,
  output logic [PAY_W-1:0]  pay_o
);

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;
  logic              take;
  logic [DIV_W-1:0]  rem_d, rem_q;
  logic [DIV_W-1:0]  div_q;
  logic [QUOT_W-1:0] quot_d, quot_q;
  logic [PAY_W-1:0]  pay_q;
  logic              valid_q;

  // Shift in one zero, subtract the divisor where it fits.
  always_comb begin
    shifted = {rem_i, 1'b0};
    trial   = shifted - {1'b0, div_i};
    take    = (shifted >= {1'b0, div_i});
    rem_d   = take ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    quot_d  = {quot_i[QUOT_W-2:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      quot_q <= quot_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quot_o  = quot_q;
  assign pay_o   = pay_q;

endmodule

@@ hdl/rgc_seg_stage.sv @@
// rgc_seg_stage: forms t from the first divider, picks the gradient segment
// and registers the start of the second division. Uses rgc_pkg.
module rgc_seg_stage import rgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       mode_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic             sat_i,
  input  logic [FracW-1:0] quot_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [TW-1:0]    rem_o,
  output logic [TW-1:0]    div_o,
  output blend_pay_t       pay_o
);

  logic [TW-1:0] t;
  seg_t          seg;
  logic [TW-1:0] offs;
  logic          full;
  logic [TW-1:0] rem_d, rem_q;
  logic [TW-1:0] div_q;
  blend_pay_t    pay_d, pay_q;
  logic          valid_q;

  always_comb begin
    t     = sat_i ? QOne : {1'b0, quot_i};
    seg   = seg_lookup(mode_i, t);
    offs  = t - seg.start;
    // Only the end of the last segment reaches a full fraction.
    full  = (offs == seg.len);
    rem_d = (full || seg.white) ? '0 : offs;
    pay_d.full  = full;
    pay_d.white = seg.white;
    pay_d.c1    = seg.c1;
    pay_d.c2    = seg.c2;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      div_q <= seg.len;
      pay_q <= pay_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign pay_o   = pay_q;

endmodule

@@ hdl/rgc_blend_stage.sv @@
// rgc_blend_stage: interpolates the three RGB565 channels and holds the
// finished color in the output register. Uses rgc_pkg.
module rgc_blend_stage import rgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [FracW-1:0] quot_i,
  input  blend_pay_t       pay_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [15:0]      color_o
);

  logic [TW-1:0] u;
  logic [5:0]    red, green, blue;
  logic [15:0]   color_d, color_q;
  logic          valid_q;

  always_comb begin
    u     = pay_i.full ? QOne : {1'b0, quot_i};
    red   = blend_ch({1'b0, pay_i.c1[15:11]}, {1'b0, pay_i.c2[15:11]}, u);
    green = blend_ch(pay_i.c1[10:5], pay_i.c2[10:5], u);
    blue  = blend_ch({1'b0, pay_i.c1[4:0]}, {1'b0, pay_i.c2[4:0]}, u);
    color_d = pay_i.white ? White : {red[4:0], green, blue[4:0]};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      color_q <= color_d;
    end
  end

  assign valid_o = valid_q;
  assign color_o = color_q;

endmodule

@@ hdl/rgb565_gradient_color.sv @@
// rgb565_gradient_color: top level of the RGB565 line gradient colorizer.
// Pipeline: 16 divider cells for t, one segment stage, 16 divider cells for u,
// one blend/output stage, each holding its result in its own register.
// Throughput: one transaction per cycle while results are taken; every cell retires one quotient bit.
// Reset: clears all stage valid bits and sets the gradient mode to white.
// Depends on rgc_pkg, rgc_div_cell, rgc_seg_stage and rgc_blend_stage.
module rgb565_gradient_color import rgc_pkg::*; #(
  parameter int MAX_LINE = MaxLineDefault,
  parameter int COL_W    = $clog2(MAX_LINE),
  parameter int LINE_W   = $clog2(MAX_LINE + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        gradient_mode_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [COL_W-1:0]  column_i,
  input  logic [LINE_W-1:0] line_width_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       color_o
);

  localparam int                NCell   = FracW;
  localparam int                PayW    = $bits(blend_pay_t);
  localparam logic [LINE_W-1:0] MaxLine = LINE_W'(MAX_LINE);

  // Mode register; writes are taken at any time, the user keeps them idle.
  logic [2:0] gradient_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gradient_mode_q <= MODE_WHITE;
    end else if (cfg_valid_i) begin
      gradient_mode_q <= gradient_mode_i;
    end
  end

  // Head of the first divider: clamp the width and flag the saturated case
  // (zero width or column at/past the end), which forces t to 1.0.
  logic [LINE_W-1:0] width;
  logic [LINE_W-1:0] col_ext;
  logic              sat;

  always_comb begin
    width   = (line_width_i > MaxLine) ? MaxLine : line_width_i;
    col_ext = LINE_W'(column_i);
    sat     = (width == '0) || (col_ext >= width);
  end

  // First chain: t = floor(column * 2^16 / width), one quotient bit per cell.
  // The ready path runs back from the output so bubbles collapse.
  logic              a_valid [NCell+1];
  logic              a_ready [NCell+1];
  logic [LINE_W-1:0] a_rem   [NCell+1];
  logic [LINE_W-1:0] a_div   [NCell+1];
  logic [FracW-1:0]  a_quot  [NCell+1];
  logic              a_sat   [NCell+1];

  assign a_valid[0] = in_valid_i;
  assign a_rem[0]   = sat ? '0 : col_ext;
  assign a_div[0]   = width;
  assign a_quot[0]  = '0;
  assign a_sat[0]   = sat;
  assign in_ready_o = a_ready[0];

  for (genvar k = 0; k < NCell; k++) begin : g_t_cell
    rgc_div_cell #(
      .DIV_W  (LINE_W),
      .QUOT_W (FracW),
      .PAY_W  (1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (a_valid[k]),
      .ready_o (a_ready[k]),
      .rem_i   (a_rem[k]),
      .div_i   (a_div[k]),
      .quot_i  (a_quot[k]),
      .pay_i   (a_sat[k]),
      .valid_o (a_valid[k+1]),
      .ready_i (a_ready[k+1]),
      .rem_o   (a_rem[k+1]),
      .div_o   (a_div[k+1]),
      .quot_o  (a_quot[k+1]),
      .pay_o   (a_sat[k+1])
    );
  end

  // Segment select and start of the local fraction division.
  logic              b_valid [NCell+1];
  logic              b_ready [NCell+1];
  logic [TW-1:0]     b_rem   [NCell+1];
  logic [TW-1:0]     b_div   [NCell+1];
  logic [FracW-1:0]  b_quot  [NCell+1];
  logic [PayW-1:0]   b_pay   [NCell+1];
  blend_pay_t        seg_pay;

  rgc_seg_stage u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (gradient_mode_q),
    .valid_i (a_valid[NCell]),
    .ready_o (a_ready[NCell]),
    .sat_i   (a_sat[NCell]),
    .quot_i  (a_quot[NCell]),
    .valid_o (b_valid[0]),
    .ready_i (b_ready[0]),
    .rem_o   (b_rem[0]),
    .div_o   (b_div[0]),
    .pay_o   (seg_pay)
  );

  assign b_pay[0]  = seg_pay;
  assign b_quot[0] = '0;

  // Second chain: u = floor((t - start) * 2^16 / segment length).
  for (genvar k = 0; k < NCell; k++) begin : g_u_cell
    rgc_div_cell #(
      .DIV_W  (TW),
      .QUOT_W (FracW),
      .PAY_W  (PayW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (b_valid[k]),
      .ready_o (b_ready[k]),
      .rem_i   (b_rem[k]),
      .div_i   (b_div[k]),
      .quot_i  (b_quot[k]),
      .pay_i   (b_pay[k]),
      .valid_o (b_valid[k+1]),
      .ready_i (b_ready[k+1]),
      .rem_o   (b_rem[k+1]),
      .div_o   (b_div[k+1]),
      .quot_o  (b_quot[k+1]),
      .pay_o   (b_pay[k+1])
    );
  end

  // Channel blend and output register.
  blend_pay_t last_pay;

  assign last_pay = blend_pay_t'(b_pay[NCell]);

  rgc_blend_stage u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid[NCell]),
    .ready_o (b_ready[NCell]),
    .quot_i  (b_quot[NCell]),
    .pay_i   (last_pay),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .color_o (color_o)
  );

  // Remainders stay below the divisor through the first chain.
  a_t_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid[NCell] && !a_sat[NCell] |-> a_rem[NCell] < a_div[NCell])
    else $error("t divider remainder not below width");

  // Same for the local fraction division, unless the fraction is full or white.
  a_u_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid[NCell] && !last_pay.full && !last_pay.white
      |-> b_rem[NCell] < b_div[NCell])
    else $error("u divider remainder not below segment length");

  // Input backpressure only ever comes from a stalled result.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

endmodule
